// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on i_clk, disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hbd assertion failed");

`define HBD_ASSERT_NEXT(lbl, pre, post) \
    `HBD_ASSERT(lbl, (pre) |=> (post))

`endif

// ===== rtl/hbd_pkg.sv =====
package hbd_pkg;

    localparam int WRAM_BYTES = 8192;
    localparam int WRAM_AW    = $clog2(WRAM_BYTES);
    localparam int HRAM_BYTES = 127;
    localparam int HRAM_AW    = $clog2(HRAM_BYTES);

    localparam logic [7:0] DMA_LENGTH      = 8'd160;
    localparam logic [1:0] DMA_START_DELAY = 2'd2;

    localparam logic [15:0] ADDR_VRAM     = 16'h8000;
    localparam logic [15:0] ADDR_XRAM     = 16'hA000;
    localparam logic [15:0] ADDR_WRAM     = 16'hC000;
    localparam logic [15:0] ADDR_OAM      = 16'hFE00;
    localparam logic [15:0] ADDR_IO       = 16'hFF00;
    localparam logic [15:0] ADDR_IF       = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA      = 16'hFF46;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
    localparam logic [15:0] ADDR_IE       = 16'hFFFF;
    localparam logic [15:0] ADDR_BOOT_END = 16'h0100;

    localparam logic [7:0] IF_FORCED = 8'hE0;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [1:0] SEL_INT  = 2'd0;
    localparam logic [1:0] SEL_BOOT = 2'd1;
    localparam logic [1:0] SEL_CART = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ
    } t_state;

    typedef enum logic [1:0] {
        SRC_REG,
        SRC_WRAM,
        SRC_HRAM
    } t_src;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_status;

endpackage

// ===== rtl/hbd_if.sv =====
interface hbd_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        from_cpu;
    logic [7:0]  ext_read_data;

    modport source (output valid, opcode, bus_address, write_data, from_cpu, ext_read_data,
                    input ready);
    modport sink   (input valid, opcode, bus_address, write_data, from_cpu, ext_read_data,
                    output ready);
endinterface

interface hbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] ext_select;
    logic       ext_write;
    logic       dma_busy;

    modport source (output valid, read_data, ext_select, ext_write, dma_busy, input ready);
    modport sink   (input valid, read_data, ext_select, ext_write, dma_busy, output ready);
endinterface

// ===== rtl/hbd_ram.sv =====
module hbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/hbd_ctrl.sv =====
module hbd_ctrl import hbd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_READ: begin
                o_cmd.load = !r_out_valid || i_out_ready;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== rtl/hbd_dp.sv =====
module hbd_dp import hbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_opcode,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_from_cpu,
    input  logic [7:0]  i_ext_read_data,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_ext_select,
    output logic        o_ext_write,
    output logic        o_dma_busy
);
    // DMA and register state
    logic       r_run, n_run;
    logic [1:0] r_wait, n_wait;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_page, n_page;
    logic [7:0] r_irq_flags, n_irq_flags;
    logic [7:0] r_irq_enable, n_irq_enable;
    logic       r_boot, n_boot;
    logic [WRAM_AW-1:0] r_clr_addr;

    // pending result
    logic [7:0] r_p_rd, n_p_rd;
    t_src       r_p_src, n_p_src;
    logic [1:0] r_p_sel, n_p_sel;
    logic       r_p_ewr, n_p_ewr;

    // output register
    logic [7:0] r_rd;
    logic [1:0] r_sel;
    logic       r_ewr;
    logic       r_busy;

    logic               is_wr, lock, in_ext, in_wram, in_hram;
    logic               wram_we, wram_re, hram_we, hram_re;
    logic [WRAM_AW-1:0] wram_addr;
    logic [HRAM_AW-1:0] hram_addr;
    logic [7:0]         wram_wdata, hram_wdata, wram_q, hram_q, rd_mux;

    always_comb begin
        is_wr = (i_opcode == OP_WRITE);

        n_run        = r_run;
        n_wait       = r_wait;
        n_cnt        = r_cnt;
        n_page       = r_page;
        n_irq_flags  = r_irq_flags;
        n_irq_enable = r_irq_enable;
        n_boot       = r_boot;
        n_p_rd       = 8'd0;
        n_p_src      = SRC_REG;
        n_p_sel      = SEL_INT;
        n_p_ewr      = 1'b0;

        if (i_from_cpu && r_run) begin
            if (r_wait != 2'd0) begin
                n_wait = r_wait - 2'd1;
            end else begin
                n_cnt = r_cnt + 8'd1;
                if (n_cnt >= DMA_LENGTH) begin
                    n_run = 1'b0;
                    n_cnt = 8'd0;
                end
            end
        end

        lock    = n_run && (i_bus_address < ADDR_IO);
        in_ext  = (i_bus_address < ADDR_VRAM)
               || (i_bus_address >= ADDR_XRAM && i_bus_address < ADDR_WRAM);
        in_wram = (i_bus_address >= ADDR_WRAM) && (i_bus_address < ADDR_OAM);
        in_hram = (i_bus_address >= ADDR_HRAM) && (i_bus_address < ADDR_IE);

        if (lock) begin
            n_p_sel = SEL_INT;
        end else if (in_ext) begin
            if (is_wr) begin
                n_p_sel = SEL_CART;
                n_p_ewr = 1'b1;
            end else if (i_bus_address < ADDR_BOOT_END && r_boot) begin
                n_p_sel = SEL_BOOT;
                n_p_rd  = i_ext_read_data;
            end else begin
                n_p_sel = SEL_CART;
                n_p_rd  = i_ext_read_data;
            end
        end else if (in_wram) begin
            if (!is_wr) begin
                n_p_src = SRC_WRAM;
            end
        end else if (in_hram) begin
            if (!is_wr) begin
                n_p_src = SRC_HRAM;
            end
        end else if (i_bus_address == ADDR_IE) begin
            if (is_wr) begin
                n_irq_enable = i_write_data;
            end else begin
                n_p_rd = r_irq_enable;
            end
        end else if (i_bus_address == ADDR_IF) begin
            if (is_wr) begin
                n_irq_flags = i_write_data | IF_FORCED;
            end else begin
                n_p_rd = r_irq_flags | IF_FORCED;
            end
        end else if (i_bus_address == ADDR_DMA) begin
            if (is_wr) begin
                n_page = i_write_data;
                n_wait = DMA_START_DELAY;
                n_cnt  = 8'd0;
                n_run  = 1'b1;
            end else begin
                n_p_rd = r_page;
            end
        end else if (i_bus_address == ADDR_BOOT_OFF) begin
            if (is_wr && i_write_data != 8'd0) begin
                n_boot = 1'b0;
            end
        end
    end

    always_comb begin
        if (i_cmd.clear) begin
            wram_addr  = r_clr_addr;
            hram_addr  = r_clr_addr[HRAM_AW-1:0];
            wram_we    = 1'b1;
            hram_we    = (r_clr_addr < WRAM_AW'(HRAM_BYTES));
            wram_wdata = 8'd0;
            hram_wdata = 8'd0;
        end else begin
            wram_addr  = i_bus_address[WRAM_AW-1:0];
            hram_addr  = i_bus_address[HRAM_AW-1:0];
            wram_we    = i_cmd.accept && !lock && in_wram && is_wr;
            hram_we    = i_cmd.accept && !lock && in_hram && is_wr;
            wram_wdata = i_write_data;
            hram_wdata = i_write_data;
        end
        wram_re = i_cmd.accept && !lock && in_wram && !is_wr;
        hram_re = i_cmd.accept && !lock && in_hram && !is_wr;
    end

    hbd_ram #(.WIDTH(8), .DEPTH(WRAM_BYTES)) u_wram (
        .i_clk   (i_clk),
        .i_we    (wram_we),
        .i_re    (wram_re),
        .i_addr  (wram_addr),
        .i_wdata (wram_wdata),
        .o_rdata (wram_q)
    );

    hbd_ram #(.WIDTH(8), .DEPTH(HRAM_BYTES)) u_hram (
        .i_clk   (i_clk),
        .i_we    (hram_we),
        .i_re    (hram_re),
        .i_addr  (hram_addr),
        .i_wdata (hram_wdata),
        .o_rdata (hram_q)
    );

    always_comb begin
        case (r_p_src)
            SRC_WRAM: rd_mux = wram_q;
            SRC_HRAM: rd_mux = hram_q;
            default:  rd_mux = r_p_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_wait       <= 2'd0;
            r_cnt        <= 8'd0;
            r_page       <= 8'd0;
            r_irq_flags  <= IF_FORCED;
            r_irq_enable <= 8'd0;
            r_boot       <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + WRAM_AW'(1);
            end
            if (i_cmd.accept) begin
                r_run        <= n_run;
                r_wait       <= n_wait;
                r_cnt        <= n_cnt;
                r_page       <= n_page;
                r_irq_flags  <= n_irq_flags;
                r_irq_enable <= n_irq_enable;
                r_boot       <= n_boot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_rd  <= n_p_rd;
            r_p_src <= n_p_src;
            r_p_sel <= n_p_sel;
            r_p_ewr <= n_p_ewr;
        end
        if (i_cmd.load) begin
            r_rd   <= rd_mux;
            r_sel  <= r_p_sel;
            r_ewr  <= r_p_ewr;
            r_busy <= r_run;
        end
    end

    assign o_status.clr_done = (r_clr_addr == '1);
    assign o_read_data       = r_rd;
    assign o_ext_select      = r_sel;
    assign o_ext_write       = r_ewr;
    assign o_dma_busy        = r_busy;
endmodule

// ===== rtl/handheld_bus_decoder_with_dma_lock_core.sv =====
// Bus decoder with OAM DMA lock.
// i_req carries one bus access per beat (opcode, bus_address, write_data,
// from_cpu, ext_read_data); o_rsp returns one beat per access (read_data,
// ext_select, ext_write, dma_busy). Both use valid/ready.
// The request beat is decoded, the DMA ticked and the RAM read issued when
// it is taken; the pending result and registered RAM read data then load
// the output register. No new request is taken until that load is done.
// Work RAM and high RAM are single-port RAMs with a registered read.
// Reset: i_rst_n is synchronous, active low. After reset a clearing pass
// zeroes work RAM and high RAM, one entry per cycle, and the request side
// is not ready until it ends. Registers take their reset values at once
// (interrupt flags 0xE0, boot ROM mapped, DMA idle).
// Stall: a result waits in the output register while o_rsp.ready is low.
// One further request is still taken; its result waits in the datapath
// until the output register frees, and no request is taken meanwhile.
module handheld_bus_decoder_with_dma_lock_core import hbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    hbd_req_if.sink   i_req,
    hbd_rsp_if.source o_rsp
);
    t_cmd    cmd;
    t_status status;

    hbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    hbd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_req.opcode),
        .i_bus_address   (i_req.bus_address),
        .i_write_data    (i_req.write_data),
        .i_from_cpu      (i_req.from_cpu),
        .i_ext_read_data (i_req.ext_read_data),
        .o_read_data     (o_rsp.read_data),
        .o_ext_select    (o_rsp.ext_select),
        .o_ext_write     (o_rsp.ext_write),
        .o_dma_busy      (o_rsp.dma_busy)
    );
endmodule

// ===== rtl/hbd_checker.sv =====
`include "assert_macros.svh"

module hbd_checker import hbd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic [1:0] i_ext_select,
    input logic       i_ext_write,
    input logic       i_dma_busy
);
    `HBD_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)
    `HBD_ASSERT(a_busy_internal,
        (i_out_valid && i_dma_busy) |-> (i_ext_select == SEL_INT && !i_ext_write))
    `HBD_ASSERT(a_ewr_cart,
        (i_out_valid && i_ext_write) |-> (i_ext_select == SEL_CART && i_read_data == 8'd0))
    `HBD_ASSERT(a_sel_code,
        i_out_valid |-> (i_ext_select == SEL_INT || i_ext_select == SEL_BOOT
                         || i_ext_select == SEL_CART))
    `HBD_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_read_data) && $stable(i_ext_select))
endmodule

bind handheld_bus_decoder_with_dma_lock_core hbd_checker u_hbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_data  (o_rsp.read_data),
    .i_ext_select (o_rsp.ext_select),
    .i_ext_write  (o_rsp.ext_write),
    .i_dma_busy   (o_rsp.dma_busy)
);
